[rtl/bxds_pkg.sv]
// Shared types, constants and lookup tables for the box-average downsampler.
// Used by every module of the block but bxds_ram; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package bxds_pkg;

    localparam int MAX_SRC_WIDTH  = 1024;
    localparam int MAX_SRC_HEIGHT = 4096;
    localparam int MAX_FACTOR     = 8;

    // counter widths
    localparam int COL_W = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W = $clog2(MAX_SRC_HEIGHT);
    localparam int SUB_W = $clog2(MAX_FACTOR);

    // configuration register widths
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int FACTOR_CFG_W = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 2'd2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd4096;
    localparam logic [FACTOR_CFG_W-1:0] FACTOR_RESET = 4'd4;

    // stream payload widths
    localparam int PIX_W     = 8;
    localparam int OCOL_W    = 10;
    localparam int OROW_W    = 12;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // datapath widths
    localparam int PART_W      = 11;  // one block row: up to 8 * 255
    localparam int SUM_W       = 14;  // one block: up to 64 * 255
    localparam int AREA_W      = 7;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = NUM_W + RECIP_W;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;    // pixel transfer this cycle
        logic sum_en;    // column accumulator read-modify-write
        logic mul_en;    // reciprocal multiply
        logic out_load;  // load output register
    } cmd_t;

    typedef struct packed {
        logic close_col; // head pixel completes a block row
        logic blk_last;  // latched: that block row was the last of its block
        logic out_busy;  // output register full and not taken this cycle
    } status_t;

    function automatic logic [AREA_W-1:0] area_of(input logic [FACTOR_CFG_W-1:0] f);
        logic [AREA_W-1:0] a;
        case (f)
            4'd2:    a = 7'd4;
            4'd3:    a = 7'd9;
            4'd4:    a = 7'd16;
            4'd5:    a = 7'd25;
            4'd6:    a = 7'd36;
            4'd7:    a = 7'd49;
            4'd8:    a = 7'd64;
            default: a = 7'd1;
        endcase
        return a;
    endfunction

    // ceil(2^24 / (2 * f * f)); exact quotient for any 15-bit numerator
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FACTOR_CFG_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            4'd2:    r = 24'd2097152;
            4'd3:    r = 24'd932068;
            4'd4:    r = 24'd524288;
            4'd5:    r = 24'd335545;
            4'd6:    r = 24'd233017;
            4'd7:    r = 24'd171197;
            4'd8:    r = 24'd131072;
            default: r = 24'd8388608;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/bxds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bxds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bxds_ctrl.sv]
// Sequencer for the downsampler: pixel intake, accumulate, multiply, output load.
// Depends on bxds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bxds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire bxds_pkg::status_t status,
    output      bxds_pkg::cmd_t    cmd
);

    import bxds_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_RUN:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.close_col)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = status.blk_last ? ST_MUL : ST_RUN;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/bxds_datapath.sv]
// Datapath: config registers, raster counters, column accumulator line,
// reciprocal divider and output register. Depends on bxds_pkg and bxds_ram.
`timescale 1ns / 1ps
`default_nettype none

module bxds_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [bxds_pkg::PIX_W-1:0]          pixel,
    input  wire bxds_pkg::cmd_t                      cmd,
    output      bxds_pkg::status_t                   status,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [bxds_pkg::M_TDATA_W-1:0]      m_tdata,
    output      logic                                m_tlast
);

    import bxds_pkg::*;

    localparam int CBS_W = COL_W + 1;
    localparam int CX_W  = CBS_W + 1;
    localparam int RBS_W = ROW_W + 1;
    localparam int RX_W  = RBS_W + 1;
    localparam int SC_W  = SUB_W + 1;
    localparam int PAD_W = M_TDATA_W - OROW_W - OCOL_W - PIX_W;

    // configuration
    logic [WIDTH_CFG_W-1:0]  src_width_reg;
    logic [HEIGHT_CFG_W-1:0] src_height_reg;
    logic [FACTOR_CFG_W-1:0] factor_reg;
    logic [WIDTH_CFG_W-1:0]  w_eff;
    logic [HEIGHT_CFG_W-1:0] h_eff;
    logic [FACTOR_CFG_W-1:0] f_eff;

    // raster state
    logic [COL_W-1:0]  src_col_reg,     src_col_next;
    logic [ROW_W-1:0]  src_row_reg,     src_row_next;
    logic [SUB_W-1:0]  sub_col_reg,     sub_col_next;
    logic [SUB_W-1:0]  sub_row_reg,     sub_row_next;
    logic [COL_W-1:0]  block_col_reg,   block_col_next;
    logic [PART_W-1:0] row_partial_reg, row_partial_next;
    logic [CBS_W-1:0]  cbs_reg,         cbs_next;    // first column of current block
    logic [RBS_W-1:0]  rbs_reg,         rbs_next;    // first row of current block row
    logic [ROW_W-1:0]  orow_reg,        orow_next;   // output row of current block row
    logic              out_valid_reg,   out_valid_next;

    // per-block capture
    logic [PART_W-1:0] rs_reg;
    logic [COL_W-1:0]  bc_reg;
    logic [ROW_W-1:0]  or_reg;
    logic              first_reg;
    logic              last_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] prod_reg;

    // output payload
    logic [PIX_W-1:0]  avg_reg;
    logic [OCOL_W-1:0] ocol_reg;
    logic [OROW_W-1:0] orow_out_reg;
    logic              done_out_reg;

    logic              col_in;
    logic              row_in;
    logic              in_region;
    logic              closing;
    logic              end_row;
    logic              end_img;
    logic              blk_row_end;
    logic              done_now;
    logic [PART_W-1:0] rs;
    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  total;
    logic [NUM_W-1:0]  quot;
    logic [PIX_W-1:0]  avg;

    always_comb
    begin
        w_eff = (src_width_reg == '0) ? WIDTH_CFG_W'(1) :
                (src_width_reg > WIDTH_CFG_W'(MAX_SRC_WIDTH)) ?
                    WIDTH_CFG_W'(MAX_SRC_WIDTH) : src_width_reg;
        h_eff = (src_height_reg == '0) ? HEIGHT_CFG_W'(1) :
                (src_height_reg > HEIGHT_CFG_W'(MAX_SRC_HEIGHT)) ?
                    HEIGHT_CFG_W'(MAX_SRC_HEIGHT) : src_height_reg;
        f_eff = (factor_reg == '0) ? FACTOR_CFG_W'(1) :
                (factor_reg > FACTOR_CFG_W'(MAX_FACTOR)) ?
                    FACTOR_CFG_W'(MAX_FACTOR) : factor_reg;
    end

    // A column or row is inside the used area when its whole block fits.
    always_comb
    begin
        col_in      = (CX_W'(cbs_reg) + CX_W'(f_eff)) <= CX_W'(w_eff);
        row_in      = (RX_W'(rbs_reg) + RX_W'(f_eff)) <= RX_W'(h_eff);
        in_region   = col_in && row_in;
        closing     = in_region && ((SC_W'(sub_col_reg) + 1'b1) >= SC_W'(f_eff));
        blk_row_end = (SC_W'(sub_row_reg) + 1'b1) >= SC_W'(f_eff);
        end_row     = (CBS_W'(src_col_reg) + 1'b1) >= CBS_W'(w_eff);
        end_img     = (RBS_W'(src_row_reg) + 1'b1) >= RBS_W'(h_eff);
        // last block column and last block row: no further block fits
        done_now    = ((CX_W'(cbs_reg) + CX_W'({f_eff, 1'b0})) > CX_W'(w_eff)) &&
                      ((RX_W'(rbs_reg) + RX_W'({f_eff, 1'b0})) > RX_W'(h_eff));
        rs          = row_partial_reg + PART_W'(pixel);
    end

    always_comb
    begin
        src_col_next     = src_col_reg;
        src_row_next     = src_row_reg;
        sub_col_next     = sub_col_reg;
        sub_row_next     = sub_row_reg;
        block_col_next   = block_col_reg;
        row_partial_next = row_partial_reg;
        cbs_next         = cbs_reg;
        rbs_next         = rbs_reg;
        orow_next        = orow_reg;
        if (cfg_we)
        begin
            src_col_next     = '0;
            src_row_next     = '0;
            sub_col_next     = '0;
            sub_row_next     = '0;
            block_col_next   = '0;
            row_partial_next = '0;
            cbs_next         = '0;
            rbs_next         = '0;
            orow_next        = '0;
        end
        else if (cmd.accept)
        begin
            if (in_region)
            begin
                if (closing)
                begin
                    row_partial_next = '0;
                    sub_col_next     = '0;
                    block_col_next   = block_col_reg + 1'b1;
                    cbs_next         = cbs_reg + CBS_W'(f_eff);
                end
                else
                begin
                    row_partial_next = rs;
                    sub_col_next     = sub_col_reg + 1'b1;
                end
            end
            if (end_row)
            begin
                src_col_next     = '0;
                sub_col_next     = '0;
                block_col_next   = '0;
                row_partial_next = '0;
                cbs_next         = '0;
                if (row_in)
                begin
                    if (blk_row_end)
                    begin
                        sub_row_next = '0;
                        rbs_next     = rbs_reg + RBS_W'(f_eff);
                        orow_next    = orow_reg + 1'b1;
                    end
                    else
                    begin
                        sub_row_next = sub_row_reg + 1'b1;
                    end
                end
                if (end_img)
                begin
                    src_row_next = '0;
                    sub_row_next = '0;
                    rbs_next     = '0;
                    orow_next    = '0;
                end
                else
                begin
                    src_row_next = src_row_reg + 1'b1;
                end
            end
            else
            begin
                src_col_next = src_col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= WIDTH_RESET;
            src_height_reg  <= HEIGHT_RESET;
            factor_reg      <= FACTOR_RESET;
            src_col_reg     <= '0;
            src_row_reg     <= '0;
            sub_col_reg     <= '0;
            sub_row_reg     <= '0;
            block_col_reg   <= '0;
            row_partial_reg <= '0;
            cbs_reg         <= '0;
            rbs_reg         <= '0;
            orow_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                    REG_FACTOR:     factor_reg     <= cfg_data[FACTOR_CFG_W-1:0];
                    default:        ;
                endcase
            end
            src_col_reg     <= src_col_next;
            src_row_reg     <= src_row_next;
            sub_col_reg     <= sub_col_next;
            sub_row_reg     <= sub_row_next;
            block_col_reg   <= block_col_next;
            row_partial_reg <= row_partial_next;
            cbs_reg         <= cbs_next;
            rbs_reg         <= rbs_next;
            orow_reg        <= orow_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // column accumulator line: read on the pixel transfer, written in the following cycle
    bxds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SRC_WIDTH)
    ) u_colsum (
        .clk   (clk),
        .we    (cmd.sum_en),
        .waddr (bc_reg),
        .wdata (total),
        .re    (cmd.accept),
        .raddr (block_col_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        total = first_reg ? SUM_W'(rs_reg) : rdata + SUM_W'(rs_reg);
        quot  = prod_reg[RECIP_SHIFT +: NUM_W];
        avg   = (quot > NUM_W'(255)) ? 8'hFF : quot[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && closing)
        begin
            rs_reg    <= rs;
            bc_reg    <= block_col_reg;
            or_reg    <= orow_reg;
            first_reg <= (sub_row_reg == '0);
            last_reg  <= blk_row_end;
            done_reg  <= done_now;
        end
        if (cmd.sum_en)
        begin
            num_reg <= {total, 1'b0} + NUM_W'(area_of(f_eff));
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(recip_of(f_eff));
        end
        if (cmd.out_load)
        begin
            avg_reg      <= avg;
            ocol_reg     <= bc_reg;
            orow_out_reg <= or_reg;
            done_out_reg <= done_reg;
        end
    end

    always_comb
    begin
        status.close_col = closing;
        status.blk_last  = last_reg;
        status.out_busy  = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), orow_out_reg, ocol_reg, avg_reg};
    assign m_tlast  = done_out_reg;

endmodule

`default_nettype wire

[rtl/box_average_downsample.sv]
// Top level of the box-average downsampler: controller plus datapath.
// Depends on bxds_pkg, bxds_ctrl, bxds_datapath (and bxds_ram below it).
//
// Takes 8-bit alpha pixels in raster order on the s_ stream and gives one
// rounded block mean per factor-by-factor block on the m_ stream, with its
// output column and row and tlast on the last block of the image. A pixel
// is normally taken with no stall. A pixel that completes one row of a block
// stalls the input for the read-modify-write of the column accumulator RAM.
// A pixel that completes a whole block stalls it through accumulate, then
// reciprocal multiply, then output load, and for as long as the output
// register is still held by m_tready low; its result shows on m_tvalid once
// the output register is loaded. With a factor of one every pixel is a block.
// Register writes restart the image counters and are to be made only while
// idle; the block does not check it. The accumulator RAM needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module box_average_downsample (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [bxds_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] pixel
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [7:0] avg_value, [17:8] out_col, [29:18] out_row, [31:30] zero
    output      logic [bxds_pkg::M_TDATA_W-1:0]      m_tdata,
    output      logic                                m_tlast,   // image_done
    input  wire logic                                cfg_we,
    input  wire logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bxds_pkg::*;

    cmd_t    cmd;
    status_t status;

    bxds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bxds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (s_tdata[PIX_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/bxds_checker.sv]
// Port-level checks for box_average_downsample, bound to the top level.
// Depends on bxds_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module bxds_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tready,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [bxds_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                                m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // a new result is loaded only while the input side is stalled
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared outside the output load cycle");

    a_out_reload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid || !$past(s_tready))
        else $error("back-to-back result without a load cycle");

    // with the output side free, an input stall ends after accumulate, multiply and output load
    a_stall_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !$past(s_tready) && !$past(s_tready, 2) && (!m_tvalid || m_tready)
        |=> s_tready)
        else $error("input stalled too long");

endmodule

bind box_average_downsample bxds_checker u_bxds_checker (.*);

`default_nettype wire
